FILE: design/c2s_pkg.sv
// Shared constants, types and arctangent table for the spherical conversion block.
`default_nettype none

package c2s_pkg;

  // Field widths
  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int DATA_W       = 64;
  localparam int ACC_W        = 32;
  localparam int SCALE_SH     = 60 - COORD_BITS;

  // Square root datapath
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int SQRT_STEPS = COORD_BITS;
  localparam int SQ_STEP_W  = $clog2(SQRT_STEPS);

  // Gain correction: 1/K in Q31
  localparam int              GAIN_FRAC = 31;
  localparam logic [30:0]     GAIN_INV  = 31'h4DBA76D4;

  // Turn accumulator landmarks
  localparam logic [ACC_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [ACC_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [ACC_W-1:0] TURN_3QUART  = 32'hC000_0000;
  localparam logic [ANGLE_BITS-1:0] POLAR_HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  // Pipeline stage numbers (stage k is the k-th register rank from the input, stage 1 being the input registers)
  localparam int STG_AZ_OUT  = CORDIC_STEPS + 1;
  localparam int STG_GAIN    = CORDIC_STEPS + 2;
  localparam int STG_POL_IN  = CORDIC_STEPS + 3;
  localparam int LAST_STG    = 2 * CORDIC_STEPS + 3;
  localparam int STG_SQ_IN   = 2;
  localparam int STG_RAD     = SQRT_STEPS + 3;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic        [ACC_W-1:0]  acc;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic axis;
    logic zneg;
  } flags_t;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32
  function automatic logic [ACC_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [ACC_W-1:0] a;
    unique case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000029;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000003;
      5'd29:   a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/c2s_cordic_cell.sv
// One CORDIC vectoring step with its output register.
`default_nettype none

module c2s_cordic_cell
  import c2s_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic [STEP_W-1:0] step,
  input  cordic_t           d,
  output cordic_t           q
);

  logic signed [DATA_W-1:0] dx;
  logic signed [DATA_W-1:0] dy;
  logic        [ACC_W-1:0]  ang;
  cordic_t                  q_next;

  assign dx  = d.y >>> step;
  assign dy  = d.x >>> step;
  assign ang = atan_turn(step);

  // Rotate toward the x axis: the sign of y picks the direction
  always_comb begin
    if (d.y[DATA_W-1]) begin
      q_next.x   = d.x - dx;
      q_next.y   = d.y + dy;
      q_next.acc = d.acc - ang;
    end else begin
      q_next.x   = d.x + dx;
      q_next.y   = d.y - dy;
      q_next.acc = d.acc + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/c2s_sqrt_cell.sv
// One digit of the restoring integer square root with its output register.
`default_nettype none

module c2s_sqrt_cell
  import c2s_pkg::*;
(
  input  logic                 clk,
  input  logic                 adv,
  input  logic [SQ_STEP_W-1:0] step,
  input  sqrt_t                d,
  output sqrt_t                q
);

  logic [SQ_STEP_W-1:0] pos;
  logic [SQ_W:0]        bitv;
  logic [SQ_W:0]        trial;
  sqrt_t                q_next;

  // Test bit walks down two places per digit, from the top even position
  assign pos   = SQ_STEP_W'(SQRT_STEPS - 1) - step;
  assign bitv  = (SQ_W + 1)'(1) << {pos, 1'b0};
  assign trial = {1'b0, d.root} + bitv;

  always_comb begin
    if ({1'b0, d.rem} >= trial) begin
      q_next.rem  = d.rem - trial[SQ_W-1:0];
      q_next.root = (d.root >> 1) + bitv[SQ_W-1:0];
    end else begin
      q_next.rem  = d.rem;
      q_next.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/c2s_gain.sv
// CORDIC gain correction: multiply by 1/K in Q31, split into two partial products.
`default_nettype none

module c2s_gain
  import c2s_pkg::*;
(
  input  logic                     clk,
  input  logic                     adv,
  input  logic [DATA_W-1:0]        x,
  output logic signed [DATA_W-1:0] rho
);

  logic [DATA_W-GAIN_FRAC-1:0] hi;
  logic [GAIN_FRAC-1:0]        lo;
  logic [DATA_W-1:0]           hi_prod;
  logic [2*GAIN_FRAC-1:0]      lo_prod;
  logic [DATA_W-1:0]           hi_p;
  logic [2*GAIN_FRAC-1:0]      lo_p;

  assign hi      = x[DATA_W-1:GAIN_FRAC];
  assign lo      = x[GAIN_FRAC-1:0];
  assign hi_prod = hi * GAIN_INV;
  assign lo_prod = lo * GAIN_INV;

  always_ff @(posedge clk) begin
    if (adv) begin
      hi_p <= hi_prod;
      lo_p <= lo_prod;
    end
  end

  // Drop the fraction of the low product, then add
  assign rho = hi_p + DATA_W'(lo_p >> GAIN_FRAC);

endmodule

`default_nettype wire

FILE: design/cartesian_to_spherical.sv
// Top level: Cartesian point to azimuth, polar angle and radius.
`default_nettype none

// Converts a signed fixed-point point (x_in, y_in, z_in) into azimuth (fraction
// of a turn, [0, 2pi)), polar angle from +z (units of pi/2^(ANGLE_BITS-1),
// [0, pi]) and the Euclidean radius rounded to nearest, in the input scale.
// The block takes one point per clock: a new point may transfer on every cycle
// that point_ready is high. Each point passes through one input register, the
// 30-cell azimuth CORDIC chain, two gain-correction stages, the 30-cell polar
// CORDIC chain and one output register. The radius runs in parallel through a
// 24-cell square-root chain and waits in a delay line. The whole pipeline
// advances together; a two-entry output buffer (output register plus skid
// register) lets one more result drain while the output side stalls, and
// point_ready drops only once that skid entry is in use. Points on the z axis
// give a zero azimuth and a polar angle of 0 or pi; the origin gives all zeros.
module cartesian_to_spherical
  import c2s_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         point_valid,
  output logic                         point_ready,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  input  logic signed [COORD_BITS-1:0] z_in,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [ANGLE_BITS-1:0]        azimuth,
  output logic [ANGLE_BITS-1:0]        polar_angle,
  output logic [COORD_BITS-1:0]        radius
);

  // Place a (COORD_BITS+1)-bit signed value into the CORDIC word scale
  function automatic logic signed [DATA_W-1:0] scale_up(input logic signed [COORD_BITS:0] v);
    return {{(DATA_W - COORD_BITS - 1 - SCALE_SH){v[COORD_BITS]}}, v, {SCALE_SH{1'b0}}};
  endfunction

  // Round a turn accumulator half up to ANGLE_BITS, keeping the carry
  function automatic logic [ANGLE_BITS:0] turn_round(input logic [ACC_W-1:0] a);
    logic [ACC_W:0] s;
    s = {1'b0, a} + ((ACC_W + 1)'(1) << (ACC_W - 1 - ANGLE_BITS));
    return s[ACC_W:ACC_W-ANGLE_BITS];
  endfunction

  // Global advance: the pipeline moves whenever the skid entry is free
  logic adv;
  logic skid_valid;

  assign adv         = !skid_valid;
  assign point_ready = adv;

  // Valid line, one bit per stage
  logic [LAST_STG:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST_STG-1:1], point_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: fold the point into the right half plane, square the magnitudes
  // ---------------------------------------------------------------------------
  logic                         xneg;
  logic signed [COORD_BITS:0]   xe;
  logic signed [COORD_BITS:0]   ye;
  logic [COORD_BITS-1:0]        ax;
  logic [COORD_BITS-1:0]        ay;
  logic [COORD_BITS-1:0]        az;
  cordic_t                      az_in;
  logic [SQ_W-1:0]              sqx;
  logic [SQ_W-1:0]              sqy;
  logic [SQ_W-1:0]              sqz;

  assign xneg = x_in[COORD_BITS-1];
  assign xe   = xneg ? -{x_in[COORD_BITS-1], x_in} : {x_in[COORD_BITS-1], x_in};
  assign ye   = xneg ? -{y_in[COORD_BITS-1], y_in} : {y_in[COORD_BITS-1], y_in};
  assign ax   = x_in[COORD_BITS-1] ? -x_in : x_in;
  assign ay   = y_in[COORD_BITS-1] ? -y_in : y_in;
  assign az   = z_in[COORD_BITS-1] ? -z_in : z_in;

  always_ff @(posedge clk) begin
    if (adv) begin
      az_in.x   <= scale_up(xe);
      az_in.y   <= scale_up(ye);
      az_in.acc <= xneg ? TURN_HALF : '0;
      sqx       <= ax * ax;
      sqy       <= ay * ay;
      sqz       <= az * az;
    end
  end

  // Carry z to the polar setup and the axis flags to the output
  logic [COORD_BITS-1:0] z_d    [1:STG_GAIN];
  flags_t                flag_d [1:LAST_STG];

  always_ff @(posedge clk) begin
    if (adv) begin
      z_d[1]           <= z_in;
      flag_d[1].axis   <= (x_in == '0) && (y_in == '0);
      flag_d[1].zneg   <= z_in[COORD_BITS-1];
      for (int k = 2; k <= STG_GAIN; k++) begin
        z_d[k] <= z_d[k-1];
      end
      for (int k = 2; k <= LAST_STG; k++) begin
        flag_d[k] <= flag_d[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Azimuth CORDIC chain
  // ---------------------------------------------------------------------------
  cordic_t az_st [0:CORDIC_STEPS-1];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_az
    c2s_cordic_cell u_cell (
      .clk  (clk),
      .adv  (adv),
      .step (STEP_W'(i)),
      .d    ((i == 0) ? az_in : az_st[(i == 0) ? 0 : i - 1]),
      .q    (az_st[i])
    );
  end

  // Round the azimuth once and hold it until the output
  logic [ANGLE_BITS:0]   az_rnd;
  logic [ANGLE_BITS-1:0] azr_d [STG_GAIN:LAST_STG];

  assign az_rnd = turn_round(az_st[CORDIC_STEPS-1].acc);

  always_ff @(posedge clk) begin
    if (adv) begin
      azr_d[STG_GAIN] <= az_rnd[ANGLE_BITS-1:0];
      for (int k = STG_GAIN + 1; k <= LAST_STG; k++) begin
        azr_d[k] <= azr_d[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Gain correction and polar setup
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0]   rho;
  logic signed [COORD_BITS:0] zg;
  logic                       zg_neg;
  cordic_t                    pol_in;

  c2s_gain u_gain (
    .clk (clk),
    .adv (adv),
    .x   (az_st[CORDIC_STEPS-1].x),
    .rho (rho)
  );

  assign zg_neg = z_d[STG_GAIN][COORD_BITS-1];
  assign zg     = {z_d[STG_GAIN][COORD_BITS-1], z_d[STG_GAIN]};

  // Below the xy plane, pre-rotate by a quarter turn so the vector starts in
  // the right half plane
  always_ff @(posedge clk) begin
    if (adv) begin
      if (zg_neg) begin
        pol_in.x   <= rho;
        pol_in.y   <= scale_up(-zg);
        pol_in.acc <= TURN_QUARTER;
      end else begin
        pol_in.x   <= scale_up(zg);
        pol_in.y   <= rho;
        pol_in.acc <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Polar CORDIC chain
  // ---------------------------------------------------------------------------
  cordic_t pol_st [0:CORDIC_STEPS-1];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pol
    c2s_cordic_cell u_cell (
      .clk  (clk),
      .adv  (adv),
      .step (STEP_W'(i)),
      .d    ((i == 0) ? pol_in : pol_st[(i == 0) ? 0 : i - 1]),
      .q    (pol_st[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Radius: sum of squares, square-root chain, round, delay
  // ---------------------------------------------------------------------------
  sqrt_t sq_in;
  sqrt_t sq_st [0:SQRT_STEPS-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_in.rem  <= sqx + sqy + sqz;
      sq_in.root <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    c2s_sqrt_cell u_cell (
      .clk  (clk),
      .adv  (adv),
      .step (SQ_STEP_W'(j)),
      .d    ((j == 0) ? sq_in : sq_st[(j == 0) ? 0 : j - 1]),
      .q    (sq_st[j])
    );
  end

  logic [SQ_W-1:0]       root_rnd;
  logic [COORD_BITS-1:0] rad_d [STG_RAD:LAST_STG];

  // Round up when the remainder exceeds the floor root
  assign root_rnd = sq_st[SQRT_STEPS-1].root +
                    SQ_W'(sq_st[SQRT_STEPS-1].rem > sq_st[SQRT_STEPS-1].root);

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_d[STG_RAD] <= root_rnd[COORD_BITS-1:0];
      for (int k = STG_RAD + 1; k <= LAST_STG; k++) begin
        rad_d[k] <= rad_d[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result forming
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0]      pacc;
  logic [ANGLE_BITS:0]   pol_rnd;
  logic [ANGLE_BITS-1:0] res_az;
  logic [ANGLE_BITS-1:0] res_pol;
  logic [COORD_BITS-1:0] res_rad;
  logic                  push;

  assign pacc    = pol_st[CORDIC_STEPS-1].acc;
  assign pol_rnd = turn_round(pacc);
  assign res_rad = rad_d[LAST_STG];
  assign push    = adv && vld[LAST_STG];

  always_comb begin
    if (flag_d[LAST_STG].axis) begin
      // On the z axis: no azimuth, polar angle from the sign of z
      res_az  = '0;
      res_pol = flag_d[LAST_STG].zneg ? POLAR_HALF : '0;
    end else begin
      res_az = azr_d[LAST_STG];
      if (pacc >= TURN_3QUART) begin
        // Tiny negative error wraps into the last quarter turn
        res_pol = '0;
      end else if (pol_rnd > {1'b0, POLAR_HALF}) begin
        res_pol = POLAR_HALF;
      end else begin
        res_pol = pol_rnd[ANGLE_BITS-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register
  // ---------------------------------------------------------------------------
  logic                  pop;
  logic [ANGLE_BITS-1:0] skid_az;
  logic [ANGLE_BITS-1:0] skid_pol;
  logic [COORD_BITS-1:0] skid_rad;

  assign pop = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (skid_valid) begin
        // Pipeline is held; drain the skid entry on a transfer
        if (pop) begin
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
        end
      end else if (result_valid && !pop) begin
        // Output register busy: park a new result in the skid entry
        if (push) begin
          skid_valid <= 1'b1;
        end
      end else begin
        result_valid <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        azimuth     <= skid_az;
        polar_angle <= skid_pol;
        radius      <= skid_rad;
      end
    end else if (result_valid && !pop) begin
      if (push) begin
        skid_az  <= res_az;
        skid_pol <= res_pol;
        skid_rad <= res_rad;
      end
    end else if (push) begin
      azimuth     <= res_az;
      polar_angle <= res_pol;
      radius      <= res_rad;
    end
  end

endmodule

`default_nettype wire
